>>> sv/mtc_pkg.sv
`timescale 1ns / 1ps

package mtc_pkg;

  // ASCII codes used on both sides of the codec
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // Longest code in the table, symbol count and longest result run
  localparam int CODE_MAX_LEN = 5;
  localparam int SYMBOL_COUNT = 36;
  localparam int RUN_MAX      = 6;

  typedef struct packed {
    logic [2:0] len;
    logic [4:0] pat;  // bit i is symbol i, 1 = dash
  } code_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] idx;
  } sym_t;

  // Map a letter (either case) or digit onto its table index
  function automatic sym_t sym_index(input logic [7:0] c);
    sym_t s;
    s = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      s.valid = 1'b1;
      s.idx   = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s.valid = 1'b1;
      s.idx   = 6'(c - 8'h61);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s.valid = 1'b1;
      s.idx   = 6'(c - 8'h30 + 8'd26);
    end
    return s;
  endfunction

  // ASCII character of a table index
  function automatic logic [7:0] sym_char(input logic [5:0] idx);
    logic [7:0] c;
    if (idx < 6'd26) begin
      c = 8'h61 + {2'b00, idx};
    end else begin
      c = 8'h30 + {2'b00, idx} - 8'd26;
    end
    return c;
  endfunction

  // Morse code of each letter and digit
  function automatic code_t code_of(input logic [5:0] idx);
    code_t k;
    case (idx)
      6'd0:    k = '{3'd2, 5'b00010};
      6'd1:    k = '{3'd4, 5'b00001};
      6'd2:    k = '{3'd4, 5'b00101};
      6'd3:    k = '{3'd3, 5'b00001};
      6'd4:    k = '{3'd1, 5'b00000};
      6'd5:    k = '{3'd4, 5'b00100};
      6'd6:    k = '{3'd3, 5'b00011};
      6'd7:    k = '{3'd4, 5'b00000};
      6'd8:    k = '{3'd2, 5'b00000};
      6'd9:    k = '{3'd4, 5'b01110};
      6'd10:   k = '{3'd3, 5'b00101};
      6'd11:   k = '{3'd4, 5'b00010};
      6'd12:   k = '{3'd2, 5'b00011};
      6'd13:   k = '{3'd2, 5'b00001};
      6'd14:   k = '{3'd3, 5'b00111};
      6'd15:   k = '{3'd4, 5'b00110};
      6'd16:   k = '{3'd4, 5'b01011};
      6'd17:   k = '{3'd3, 5'b00010};
      6'd18:   k = '{3'd3, 5'b00000};
      6'd19:   k = '{3'd1, 5'b00001};
      6'd20:   k = '{3'd3, 5'b00100};
      6'd21:   k = '{3'd4, 5'b01000};
      6'd22:   k = '{3'd3, 5'b00110};
      6'd23:   k = '{3'd4, 5'b01001};
      6'd24:   k = '{3'd4, 5'b01101};
      6'd25:   k = '{3'd4, 5'b00011};
      6'd26:   k = '{3'd5, 5'b11111};
      6'd27:   k = '{3'd5, 5'b11110};
      6'd28:   k = '{3'd5, 5'b11100};
      6'd29:   k = '{3'd5, 5'b11000};
      6'd30:   k = '{3'd5, 5'b10000};
      6'd31:   k = '{3'd5, 5'b00000};
      6'd32:   k = '{3'd5, 5'b00001};
      6'd33:   k = '{3'd5, 5'b00011};
      6'd34:   k = '{3'd5, 5'b00111};
      6'd35:   k = '{3'd5, 5'b01111};
      default: k = '0;
    endcase
    return k;
  endfunction

  // Reverse lookup: compare against every table entry, 0 when none matches
  function automatic logic [7:0] code_lookup(input code_t key);
    logic [7:0] c;
    c = CH_NUL;
    for (int i = 0; i < SYMBOL_COUNT; i++) begin
      if (code_of(6'(i)) == key) begin
        c = sym_char(6'(i));
      end
    end
    return c;
  endfunction

endpackage

>>> sv/morse_text_codec_top.sv
`timescale 1ns / 1ps

// Morse text codec. With direction at 0 each ASCII character becomes its
// dots and dashes plus a letter gap (two spaces for a space, one space for
// anything else); with direction at 1 a stream of '.', '-' and spaces is
// collected into letters, and end_of_message flushes the pending letter.
// Results leave one per cycle while out_ready allows, from a six-entry run
// buffer through an output register. Every encode item gives at least one
// result and an encoded digit gives six; a decode item may give none. A new
// item is taken in the cycle the last result of the previous one moves to
// the output register, so items that give one result or none stream at one
// per cycle while out_ready allows.
module morse_text_codec_top
  import mtc_pkg::*;
#(
  parameter int MAX_CODE_LENGTH = 5
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       end_of_message,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       last_of_run
);

  localparam int LW = $clog2(MAX_CODE_LENGTH + 1);
  localparam int CW = $clog2(RUN_MAX + 1);

  logic                       direction;
  logic [MAX_CODE_LENGTH-1:0] pending_pattern;
  logic [LW-1:0]              pending_length;
  logic                       pending_invalid;
  logic                       previous_was_space;

  logic [MAX_CODE_LENGTH-1:0] pending_pattern_next;
  logic [LW-1:0]              pending_length_next;
  logic                       pending_invalid_next;
  logic                       previous_was_space_next;

  logic [7:0]    run_chars [RUN_MAX];
  logic [CW-1:0] run_left;

  logic [7:0]    res_chars [RUN_MAX];
  logic [CW-1:0] res_count;

  logic in_xfer;
  logic load_out;

  logic       is_dot, is_dash, is_space;
  sym_t       sym;
  code_t      enc;
  logic       first_emit, flush_emit;
  logic [7:0] first_char, flush_char;

  // Decode a pending sequence; overlong or foreign input gives 0
  function automatic logic [7:0] decode_pending(
    input logic [MAX_CODE_LENGTH-1:0] pat,
    input logic [LW-1:0]              len,
    input logic                       inv
  );
    logic [7:0] c;
    if (inv || len > LW'(CODE_MAX_LEN)) begin
      c = CH_NUL;
    end else begin
      c = code_lookup('{len[2:0], pat[4:0]});
    end
    return c;
  endfunction

  assign load_out = (run_left != '0) && (!out_valid || out_ready);
  assign in_ready = (run_left == '0) || (run_left == CW'(1) && load_out);
  assign in_xfer  = in_valid && in_ready;

  assign is_dot   = (in_char == CH_DOT);
  assign is_dash  = (in_char == CH_DASH);
  assign is_space = (in_char == CH_SPACE);
  assign sym      = sym_index(in_char);
  assign enc      = code_of(sym.idx);

  // Work out the decode state and the result run of the offered item
  always_comb begin
    pending_pattern_next    = pending_pattern;
    pending_length_next     = pending_length;
    pending_invalid_next    = pending_invalid;
    previous_was_space_next = previous_was_space;
    first_emit              = 1'b0;
    first_char              = decode_pending(pending_pattern, pending_length,
                                             pending_invalid);

    if (is_dot || is_dash) begin
      if (pending_length < LW'(MAX_CODE_LENGTH)) begin
        pending_pattern_next = pending_pattern
                               | (MAX_CODE_LENGTH'(is_dash) << pending_length);
        pending_length_next  = pending_length + LW'(1);
      end else begin
        pending_invalid_next = 1'b1;
      end
      previous_was_space_next = 1'b0;
    end else if (is_space) begin
      if (previous_was_space) begin
        first_emit = 1'b1;
        first_char = CH_SPACE;
      end else if (pending_length != '0 || pending_invalid) begin
        first_emit = 1'b1;
      end
      pending_pattern_next    = '0;
      pending_length_next     = '0;
      pending_invalid_next    = 1'b0;
      previous_was_space_next = 1'b1;
    end else begin
      pending_invalid_next    = 1'b1;
      previous_was_space_next = 1'b0;
    end

    // Flush on end of message
    flush_emit = end_of_message
                 && (pending_length_next != '0 || pending_invalid_next);
    flush_char = decode_pending(pending_pattern_next, pending_length_next,
                                pending_invalid_next);
    if (end_of_message) begin
      pending_pattern_next    = '0;
      pending_length_next     = '0;
      pending_invalid_next    = 1'b0;
      previous_was_space_next = 1'b0;
    end

    // Build the run: encode fills spaces after the code symbols
    for (int k = 0; k < RUN_MAX; k++) begin
      res_chars[k] = CH_SPACE;
    end
    if (!direction) begin
      if (sym.valid) begin
        for (int k = 0; k < CODE_MAX_LEN; k++) begin
          if (k < int'(enc.len)) begin
            res_chars[k] = enc.pat[k] ? CH_DASH : CH_DOT;
          end
        end
        res_count = CW'(enc.len) + CW'(1);
      end else if (is_space) begin
        res_count = CW'(2);
      end else begin
        res_count = CW'(1);
      end
    end else begin
      res_chars[0] = first_emit ? first_char : flush_char;
      res_chars[1] = flush_char;
      res_count    = CW'(first_emit) + CW'(flush_emit);
    end
  end

  // Hold the direction register
  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= 1'b0;
    end else if (cfg_write) begin
      direction <= cfg_data;
    end
  end

  // Advance the decode state on each decode transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_pattern    <= '0;
      pending_length     <= '0;
      pending_invalid    <= 1'b0;
      previous_was_space <= 1'b0;
    end else if (in_xfer && direction) begin
      pending_pattern    <= pending_pattern_next;
      pending_length     <= pending_length_next;
      pending_invalid    <= pending_invalid_next;
      previous_was_space <= previous_was_space_next;
    end
  end

  // Load a new run on transfer, else shift one result out
  always_ff @(posedge clk) begin
    if (rst) begin
      run_left <= '0;
    end else if (in_xfer) begin
      run_left <= res_count;
    end else if (load_out) begin
      run_left <= run_left - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      for (int i = 0; i < RUN_MAX; i++) begin
        run_chars[i] <= res_chars[i];
      end
    end else if (load_out) begin
      for (int i = 0; i < RUN_MAX - 1; i++) begin
        run_chars[i] <= run_chars[i + 1];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_char    <= run_chars[0];
      last_of_run <= (run_left == CW'(1));
    end
  end

  // Run buffer never holds more than the longest run
  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    run_left <= CW'(RUN_MAX))
    else $error("run buffer count out of range");

  // Only take an item when the previous run is done or finishing
  a_ready_run: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> run_left <= CW'(1))
    else $error("item taken while run still pending");

  // Every encode item gives at least one result
  a_encode_run: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && !direction) |=> run_left != '0)
    else $error("encode item gave no result");

  // End of message leaves the decode state clear
  a_eom_clear: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && direction && end_of_message) |=>
      (pending_length == '0 && !pending_invalid && !previous_was_space))
    else $error("decode state not cleared after end of message");

  // The final entry of a run is marked last
  a_last_mark: assert property (@(posedge clk) disable iff (rst)
    (load_out && run_left == CW'(1)) |=> (out_valid && last_of_run))
    else $error("last result of run not marked");

endmodule
